FILE: sv/ordered_gate_edge_timestamper_core_defines.svh
// assertion macros for the port-level checker
`ifndef ORDERED_GATE_EDGE_TIMESTAMPER_CORE_DEFINES_SVH
`define ORDERED_GATE_EDGE_TIMESTAMPER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define OGETS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OGETS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ogets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogets_pkg
// Shared constants, types and the gate position table of the gate timestamper.
// ----------------------------------------------------------------------------
package ogets_pkg;

  localparam int GATE_COUNT  = 9;
  localparam int TIME_BITS   = 32;
  localparam int IDX_W       = $clog2(GATE_COUNT + 1);
  localparam int CENTRE_GATE = GATE_COUNT / 2;
  localparam int CMP_W       = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;
  localparam logic [1:0] KIND_EMPTY  = 2'd3;

  localparam logic signed [12:0] GATE_POS [16] = '{
    -13'sd2185, -13'sd1092, -13'sd728, -13'sd364, 13'sd0, 13'sd364, 13'sd728,
    13'sd1092, 13'sd2185, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0
  };

  typedef struct packed {
    logic                 sample;
    logic                 clear;
    logic                 load;
    logic                 shift;
    logic [IDX_W-1:0]     start;
    logic [TIME_BITS-1:0] now;
  } cell_ctl_t;

  typedef struct packed {
    logic                 fired;
    logic [TIME_BITS-1:0] t;
  } rd_beat_t;

  function automatic logic signed [12:0] gate_position(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    if (wide < 32'd16) begin
      return GATE_POS[wide[3:0]];
    end
    return 13'sd0;
  endfunction

endpackage

FILE: sv/ogets_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogets_in_if
// Request channel: request type, gate levels and current time.
// ----------------------------------------------------------------------------
interface ogets_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [8:0]  gate_levels;
  logic [31:0] now_us;

  modport source (output valid, req_type, gate_levels, now_us, input ready);
  modport sink (input valid, req_type, gate_levels, now_us, output ready);
endinterface

FILE: sv/ogets_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogets_out_if
// Result channel: status, readout entries and the last-beat mark.
// ----------------------------------------------------------------------------
interface ogets_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic               ready_res;
  logic [3:0]         next_expected;
  logic [3:0]         gate_index;
  logic [31:0]        capture_time;
  logic signed [12:0] position_tenths_mm;
  logic [31:0]        central_time;
  logic               last;

  modport source (
    output valid, result_kind, ready_res, next_expected, gate_index, capture_time,
           position_tenths_mm, central_time, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, ready_res, next_expected, gate_index, capture_time,
           position_tenths_mm, central_time, last,
    output ready
  );
endinterface

FILE: sv/ordered_gate_edge_timestamper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_gate_edge_timestamper_core
// Ordered light-gate falling-edge timestamper built from a row of gate cells.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  in_ch    | in  | req_type, gate_levels, now_us
//  out_ch   | out | result_kind, ready_res, next_expected, gate_index,
//           |     | capture_time, position_tenths_mm, central_time, last
//  cfg      | in  | cfg_we, cfg_wdata (timeout_us)
//
// sample and clear: accepted in S_IDLE, result registered from S_EVAL once out_ch
// has room; no new request is taken until that result is registered
// readout: the entries are shifted out through the cell row
// reset: no clearing pass; out_ch stalls hold the row in place
// ----------------------------------------------------------------------------
module ordered_gate_edge_timestamper_core
  import ogets_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ogets_in_if.sink    in_ch,
  ogets_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [31:0]          timeout;
  logic [1:0]           req;
  logic [TIME_BITS-1:0] now;
  logic [IDX_W-1:0]     expected;
  logic [TIME_BITS-1:0] last_edge_time;
  logic [TIME_BITS-1:0] centre_edge_time;
  logic [IDX_W-1:0]     rd_idx;

  logic                 accept;
  logic                 slot_free;
  logic                 emit;
  cell_ctl_t            ctl;
  logic [IDX_W-1:0]     hit_link [GATE_COUNT+1];
  rd_beat_t             rd_link [GATE_COUNT+1];
  logic                 any_link [GATE_COUNT+1];
  logic [GATE_COUNT-1:0] fired_v;
  logic [GATE_COUNT-1:0] fire_v;
  logic [TIME_BITS-1:0] since;
  logic                 rdy;

  logic [1:0]           kind_next;
  logic                 last_next;
  logic                 entry_next;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign slot_free = !out_ch.valid || out_ch.ready;

  assign ctl.sample = accept && (in_ch.req_type == REQ_SAMPLE);
  assign ctl.clear  = accept && (in_ch.req_type == REQ_CLEAR);
  assign ctl.load   = accept && (in_ch.req_type == REQ_READ);
  assign ctl.shift  = (state == S_READ) && slot_free;
  assign ctl.start  = expected;
  assign ctl.now    = TIME_BITS'(in_ch.now_us);

  assign hit_link[0]          = expected;
  assign rd_link[GATE_COUNT]  = '0;
  assign any_link[GATE_COUNT] = 1'b0;

  for (genvar g = 0; g < GATE_COUNT; g++) begin : g_cell
    ogets_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .idx     (IDX_W'(g)),
      .level   (in_ch.gate_levels[g]),
      .hit_in  (hit_link[g]),
      .hit_out (hit_link[g+1]),
      .rd_in   (rd_link[g+1]),
      .rd_out  (rd_link[g]),
      .any_in  (any_link[g+1]),
      .any_out (any_link[g]),
      .fired   (fired_v[g]),
      .fire    (fire_v[g])
    );
  end

  // ready flag from settled state and the item's time
  assign since = now - last_edge_time;
  assign rdy = ((CMP_W'(since) > CMP_W'(timeout)) && (expected != '0)) ||
               (fired_v[CENTRE_GATE] && (|fired_v[CENTRE_GATE-1:0]) &&
                (|fired_v[GATE_COUNT-1:CENTRE_GATE+1]));

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    kind_next  = KIND_STATUS;
    last_next  = 1'b1;
    entry_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (slot_free) begin
          priority case (req)
            REQ_CLEAR: begin
              emit       = 1'b1;
              kind_next  = KIND_CLEAR;
              state_next = S_IDLE;
            end
            REQ_READ: begin
              if (|fired_v) begin
                state_next = S_READ;
              end else begin
                emit       = 1'b1;
                kind_next  = KIND_EMPTY;
                state_next = S_IDLE;
              end
            end
            default: begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        if (slot_free && rd_link[0].fired) begin
          emit       = 1'b1;
          entry_next = 1'b1;
          kind_next  = KIND_ENTRY;
          last_next  = !any_link[1];
          if (!any_link[1]) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      timeout          <= TIMEOUT_RESET;
      expected         <= '0;
      last_edge_time   <= '0;
      centre_edge_time <= '0;
      out_ch.valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (ctl.clear) begin
        expected       <= '0;
        last_edge_time <= '0;
      end else if (ctl.sample) begin
        expected <= hit_link[GATE_COUNT];
        if (|fire_v) begin
          last_edge_time <= ctl.now;
        end
        if (fire_v[CENTRE_GATE]) begin
          centre_edge_time <= ctl.now;
        end
      end
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_ch.req_type;
      now <= ctl.now;
    end
    if (state == S_EVAL) begin
      rd_idx <= '0;
    end else if (ctl.shift) begin
      rd_idx <= IDX_W'(rd_idx + 1'b1);
    end
    if (emit) begin
      out_ch.result_kind   <= kind_next;
      out_ch.ready_res     <= rdy;
      out_ch.next_expected <= 4'(expected);
      out_ch.central_time  <= 32'(centre_edge_time);
      out_ch.last          <= last_next;
      if (entry_next) begin
        out_ch.gate_index         <= 4'(rd_idx);
        out_ch.capture_time       <= 32'(rd_link[0].t);
        out_ch.position_tenths_mm <= gate_position(rd_idx);
      end else begin
        out_ch.gate_index         <= 4'd0;
        out_ch.capture_time       <= 32'd0;
        out_ch.position_tenths_mm <= 13'sd0;
      end
    end
  end

endmodule

FILE: sv/ogets_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogets_cell
// One gate: edge detect, timestamp, fired mark and one stage of the readout
// shift row.
// ----------------------------------------------------------------------------
module ogets_cell
  import ogets_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  logic             level,
  input  logic [IDX_W-1:0] hit_in,
  output logic [IDX_W-1:0] hit_out,
  input  rd_beat_t         rd_in,
  output rd_beat_t         rd_out,
  input  logic             any_in,
  output logic             any_out,
  output logic             fired,
  output logic             fire
);

  logic                 prev;
  logic [TIME_BITS-1:0] edge_time;
  rd_beat_t             sh;
  logic                 active;

  assign active  = (idx >= ctl.start);
  assign fire    = ctl.sample && active && prev && !level;
  assign hit_out = fire ? IDX_W'(idx + 1'b1) : hit_in;
  assign rd_out  = sh;
  assign any_out = sh.fired || any_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= 1'b1;
      fired <= 1'b0;
    end else if (ctl.clear) begin
      fired <= 1'b0;
    end else if (ctl.sample && active) begin
      prev <= level;
      if (fire) begin
        fired <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      edge_time <= ctl.now;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh.t <= edge_time;
    end else if (ctl.shift) begin
      sh.t <= rd_in.t;
    end
    if (rst) begin
      sh.fired <= 1'b0;
    end else if (ctl.load) begin
      sh.fired <= fired;
    end else if (ctl.shift) begin
      sh.fired <= rd_in.fired;
    end
  end

endmodule

FILE: sv/ogets_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogets_props
// Port-level checks of the gate timestamper, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_gate_edge_timestamper_core_defines.svh"

module ogets_props
  import ogets_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         result_kind,
  input logic [3:0]         gate_index,
  input logic [31:0]        capture_time,
  input logic signed [12:0] position_tenths_mm,
  input logic               last
);

  // a stalled beat stays
  `OGETS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(capture_time) && $stable(last), "stalled result beat changed")

  // one item in flight at a time
  `OGETS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "request taken while busy")

  // entry fields are zero outside readout entries
  `OGETS_ASSERT_NOW(a_unused_zero, out_valid && (result_kind != KIND_ENTRY), (gate_index == 4'd0) && (capture_time == 32'd0) && (position_tenths_mm == 13'sd0), "entry fields set on non-entry beat")

  // a non-entry beat always closes its item
  `OGETS_ASSERT_NOW(a_single_last, out_valid && (result_kind != KIND_ENTRY), last, "status beat without last")

endmodule

bind ordered_gate_edge_timestamper_core ogets_props u_ogets_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .result_kind        (out_ch.result_kind),
  .gate_index         (out_ch.gate_index),
  .capture_time       (out_ch.capture_time),
  .position_tenths_mm (out_ch.position_tenths_mm),
  .last               (out_ch.last)
);

FILE: tb/ogets_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogets_checker
// Watches request and result beats of the gate timestamper, keeps its own
// copy of gate levels, edge times, fired marks and the timeout register,
// works out the answers to every accepted request and compares each result
// beat field by field with the oldest answer still owed.
// ----------------------------------------------------------------------------
module ogets_checker
  import ogets_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ogets_in_if         in_ch,
  ogets_out_if        out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          outstanding,
  output int          beats_checked,
  output int          ready_beats
);

  typedef struct {
    logic [1:0]         kind;
    logic               rdy;
    logic [3:0]         next_idx;
    logic [3:0]         gate;
    logic [31:0]        stamp;
    logic signed [12:0] pos;
    logic [31:0]        centre;
    logic               last;
  } gate_beat_t;

  localparam logic signed [12:0] POS_TENTHS [GATE_COUNT] = '{
    -13'sd2185, -13'sd1092, -13'sd728, -13'sd364, 13'sd0,
    13'sd364, 13'sd728, 13'sd1092, 13'sd2185
  };

  logic [GATE_COUNT-1:0] gate_prev;
  logic [GATE_COUNT-1:0] gate_fired;
  logic [31:0]           gate_time [GATE_COUNT];
  logic [3:0]            watch_idx;
  logic [31:0]           last_fall_us;
  logic [31:0]           centre_fall_us;
  logic [31:0]           timeout_us_cfg;
  gate_beat_t            answer_q [$];

  function automatic logic data_ready(input logic [31:0] now);
    logic [31:0] span;
    logic        lo;
    logic        hi;
    span = now - last_fall_us;
    lo = 1'b0;
    hi = 1'b0;
    if (span > timeout_us_cfg && watch_idx != 4'd0) return 1'b1;
    if (!gate_fired[CENTRE_GATE]) return 1'b0;
    for (int i = 0; i < GATE_COUNT; i++) begin
      if (gate_fired[i] && i < CENTRE_GATE) lo = 1'b1;
      if (gate_fired[i] && i > CENTRE_GATE) hi = 1'b1;
    end
    return lo && hi;
  endfunction

  task automatic queue_answer(input logic [1:0] kind, input logic rdy, input logic [3:0] gate,
                              input logic [31:0] stamp, input logic signed [12:0] pos);
    gate_beat_t b;
    b.kind = kind;
    b.rdy = rdy;
    b.next_idx = watch_idx;
    b.gate = gate;
    b.stamp = stamp;
    b.pos = pos;
    b.centre = centre_fall_us;
    b.last = 1'b0;
    answer_q.insert(answer_q.size(), b);
  endtask

  task automatic predict_request(input logic [1:0] req, input logic [8:0] levels,
                                 input logic [31:0] now);
    logic [3:0] start;
    logic       rdy;
    int         hits;
    start = watch_idx;
    hits = 0;
    case (req)
      REQ_SAMPLE: begin
        for (int i = 0; i < GATE_COUNT; i++) begin
          if (i >= start) begin
            if (gate_prev[i] && !levels[i]) begin
              gate_time[i] = now;
              gate_fired[i] = 1'b1;
              if (i == CENTRE_GATE) centre_fall_us = now;
              last_fall_us = now;
              watch_idx = 4'(i + 1);
            end
            gate_prev[i] = levels[i];
          end
        end
        queue_answer(KIND_STATUS, data_ready(now), 4'd0, 32'd0, 13'sd0);
      end
      REQ_CLEAR: begin
        gate_fired = '0;
        for (int i = 0; i < GATE_COUNT; i++) gate_time[i] = '0;
        watch_idx = '0;
        last_fall_us = '0;
        queue_answer(KIND_CLEAR, data_ready(now), 4'd0, 32'd0, 13'sd0);
      end
      REQ_READ: begin
        rdy = data_ready(now);
        for (int i = 0; i < GATE_COUNT; i++) begin
          if (gate_fired[i]) begin
            queue_answer(KIND_ENTRY, rdy, 4'(i), gate_time[i], POS_TENTHS[i]);
            hits++;
          end
        end
        if (hits == 0) queue_answer(KIND_EMPTY, rdy, 4'd0, 32'd0, 13'sd0);
      end
      default: begin
        queue_answer(KIND_STATUS, data_ready(now), 4'd0, 32'd0, 13'sd0);
      end
    endcase
    answer_q[answer_q.size() - 1].last = 1'b1;
  endtask

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_beat();
    gate_beat_t want;
    if (answer_q.size() == 0) begin
      report($sformatf("result beat of kind %0d with nothing owed", out_ch.result_kind));
      return;
    end
    want = answer_q.pop_front();
    beats_checked++;
    if (want.rdy) ready_beats++;
    if (out_ch.result_kind !== want.kind)
      report($sformatf("result_kind %0d, expected %0d", out_ch.result_kind, want.kind));
    if (out_ch.ready_res !== want.rdy)
      report($sformatf("ready_res %0b, expected %0b", out_ch.ready_res, want.rdy));
    if (out_ch.next_expected !== want.next_idx)
      report($sformatf("next_expected %0d, expected %0d", out_ch.next_expected, want.next_idx));
    if (out_ch.gate_index !== want.gate)
      report($sformatf("gate_index %0d, expected %0d", out_ch.gate_index, want.gate));
    if (out_ch.capture_time !== want.stamp)
      report($sformatf("capture_time %0h, expected %0h", out_ch.capture_time, want.stamp));
    if (out_ch.position_tenths_mm !== want.pos)
      report($sformatf("position_tenths_mm %0d, expected %0d",
                       out_ch.position_tenths_mm, want.pos));
    if (out_ch.central_time !== want.centre)
      report($sformatf("central_time %0h, expected %0h", out_ch.central_time, want.centre));
    if (out_ch.last !== want.last)
      report($sformatf("last %0b, expected %0b", out_ch.last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gate_prev = '1;
      gate_fired = '0;
      for (int i = 0; i < GATE_COUNT; i++) gate_time[i] = '0;
      watch_idx = '0;
      last_fall_us = '0;
      centre_fall_us = '0;
      timeout_us_cfg = 32'd1_000_000;
      answer_q.delete();
      errors = 0;
      beats_checked = 0;
      ready_beats = 0;
    end else begin
      if (cfg_we) timeout_us_cfg = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        predict_request(in_ch.req_type, in_ch.gate_levels, in_ch.now_us);
      if (out_ch.valid && out_ch.ready) check_beat();
    end
    outstanding <= answer_q.size();
  end

endmodule

FILE: tb/ordered_gate_edge_timestamper_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_gate_edge_timestamper_core_tb
// Drives sample, clear, readout and unknown requests into the timestamper:
// a directed opening on ordering, wrap and timeout corners, then ordered
// falling-edge sequences mixed with noise under five timeout settings, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module ordered_gate_edge_timestamper_core_tb;
  import ogets_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 76;
  localparam int PHASES = 5;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          errors;
  int          outstanding;
  int          beats_checked;
  int          ready_beats;
  int          idle_cycles = 0;
  int          requests = 0;
  int          readouts = 0;
  int          clears = 0;
  int          sink_hold;
  int          sink_mode_left;
  logic        sink_busy_mode;
  logic [31:0] clock_us;
  logic [8:0]  levels_now;
  int          cursor;
  bit          sender_quiet;
  logic [31:0] timeout_set [PHASES];

  ogets_in_if  in_ch();
  ogets_out_if out_ch();

  ordered_gate_edge_timestamper_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ogets_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .outstanding   (outstanding),
    .beats_checked (beats_checked),
    .ready_beats   (ready_beats)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: stall bursts in busy stretches, none in calm ones
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_hold <= 0;
      sink_mode_left <= 0;
      sink_busy_mode <= 1'b1;
    end else begin
      if (sink_mode_left == 0) begin
        sink_mode_left <= $urandom_range(100, 400);
        sink_busy_mode <= ($urandom_range(0, 2) != 0);
      end else begin
        sink_mode_left <= sink_mode_left - 1;
      end
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else if (sink_busy_mode && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("ordered_gate_edge_timestamper_core verification failed");
      $finish;
    end
  end

  task automatic send(input logic [1:0] req, input logic [8:0] lv, input logic [31:0] now);
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.gate_levels <= lv;
    in_ch.now_us <= now;
    requests++;
    if (req == REQ_READ) readouts++;
    if (req == REQ_CLEAR) clears++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if (sender_quiet || $urandom_range(0, 9) < 7) return;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) clock_us += $urandom_range(0, 300);
    else if (r < 90) clock_us += $urandom_range(0, 3_000_000);
    else clock_us = $urandom;
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    advance_clock();
    if (pick < 7) begin
      send(REQ_CLEAR, 9'($urandom), clock_us);
    end else if (pick < 20) begin
      send(REQ_READ, 9'($urandom), clock_us);
    end else if (pick < 23) begin
      send(REQ_UNKNOWN, 9'($urandom), clock_us);
    end else if (pick < 33) begin
      levels_now = 9'($urandom);
      send(REQ_SAMPLE, levels_now, clock_us);
    end else if (cursor >= GATE_COUNT) begin
      cursor = -1;
      send(REQ_CLEAR, levels_now, clock_us);
    end else if (cursor < 0) begin
      levels_now = '1;
      cursor = 0;
      send(REQ_SAMPLE, levels_now, clock_us);
    end else begin
      // walk the row upward, sometimes skipping a gate or dropping two at once
      cursor = cursor + $urandom_range(0, 2);
      if (cursor > GATE_COUNT - 1) cursor = GATE_COUNT - 1;
      levels_now[cursor] = 1'b0;
      if ($urandom_range(0, 3) == 0 && cursor < GATE_COUNT - 1) begin
        cursor++;
        levels_now[cursor] = 1'b0;
      end
      cursor++;
      send(REQ_SAMPLE, levels_now, clock_us);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_SAMPLE;
    in_ch.gate_levels <= '0;
    in_ch.now_us <= '0;
    timeout_set[0] = 32'd0;
    timeout_set[1] = 32'hFFFF_FFFF;
    timeout_set[2] = 32'd50;
    timeout_set[3] = 32'd1_000_000;
    timeout_set[4] = $urandom_range(100, 4_000_000);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed opening under the reset timeout
    send(REQ_READ, 9'h1FF, 32'hFFF0_0000);
    send(REQ_UNKNOWN, 9'h000, 32'hFFF0_0001);
    send(REQ_SAMPLE, 9'h1FF, 32'hFFFF_FFF0);
    send(REQ_SAMPLE, 9'h1F5, 32'hFFFF_FFF4);     // two gates fall together
    send(REQ_SAMPLE, 9'h1F4, 32'hFFFF_FFF8);     // gate behind the watch index
    send(REQ_SAMPLE, 9'h1E4, 32'h0000_0005);     // centre gate after time wrap
    send(REQ_SAMPLE, 9'h0E4, 32'h0000_0009);     // far gate completes the group
    send(REQ_READ, 9'h000, 32'h0000_000A);
    send(REQ_SAMPLE, 9'h000, 32'h0000_000B);     // watch index past the row
    send(REQ_CLEAR, 9'h1FF, 32'h0000_000C);
    send(REQ_READ, 9'h1FF, 32'h0000_000D);
    send(REQ_SAMPLE, 9'h000, 32'h0000_0100);     // gates left high fall now
    send(REQ_SAMPLE, 9'h000, 32'h0000_0100 + 32'd1_000_000);
    send(REQ_SAMPLE, 9'h000, 32'h0000_0100 + 32'd1_000_001);
    send(REQ_READ, 9'h000, 32'h0000_0200 + 32'd1_000_001);
    send(REQ_CLEAR, 9'h000, 32'h8000_0000);
    send(REQ_SAMPLE, 9'h1FF, 32'h8000_0001);
    send(REQ_SAMPLE, 9'h000, 32'h8000_0002);     // whole row in one sample
    send(REQ_READ, 9'h1FF, 32'h8000_0003);
    send(REQ_CLEAR, 9'h1FF, 32'h8000_0004);

    clock_us = $urandom;
    levels_now = '1;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_timeout(timeout_set[p]);
      sender_quiet = (p == 2);
      cursor = -1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_request();
        if ($urandom_range(0, 49) == 0) drain();
        else sender_gap();
      end
    end
    drain();
    repeat (16) @(posedge clk);

    $display("sent %0d requests (%0d readouts, %0d clears) over %0d timeout settings",
             requests, readouts, clears, PHASES + 1);
    $display("compared %0d result beats, %0d of them flagged ready", beats_checked, ready_beats);
    if (errors == 0 && outstanding == 0) begin
      $display("ordered_gate_edge_timestamper_core verification clean");
    end else begin
      $display("ordered_gate_edge_timestamper_core verification failed");
    end
    $finish;
  end

endmodule
